### hw/rtl/lufm_pkg.sv
`timescale 1ns / 1ps
package lufm_pkg;
	localparam int NODES = 1024;
	localparam int LEVELS = 10;
	localparam int NODE_W = 10;
	localparam int LVL_W = 4;
	localparam int ADDR_W = LVL_W + NODE_W;
	localparam int DEPTH = LEVELS * NODES;
	localparam int ENT_W = 11;
	localparam int TOTAL_W = 14;
	localparam int MERGE_W = 4;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
	localparam logic [MERGE_W-1:0] MERGE_MAX = '1;

	// entry: [10] root flag; root holds size-1 in [9:0], else parent in [9:0]
	typedef struct packed {
		logic           start;
		logic           clear_step;
		logic           ld_a;
		logic           ld_b;
		logic           walk;
		logic           compress;
		logic           join_w;
		logic           size_w;
		logic           next_level;
		logic           finish;
	} cmd_t;

	typedef struct packed {
		logic           clear_done;
		logic           is_root;
		logic           compress_done;
		logic           same_set;
		logic           last_level;
		logic           skip;
	} sts_t;
endpackage

### hw/rtl/lufm_ram.sv
`timescale 1ns / 1ps
module lufm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### hw/rtl/lufm_datapath.sv
`timescale 1ns / 1ps
module lufm_datapath import lufm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic               in_mode,
	input  logic [NODE_W-1:0]  in_a,
	input  logic [NODE_W-1:0]  in_b,
	input  logic [3:0]         in_w,
	output logic [TOTAL_W-1:0] total_weight,
	output logic [MERGE_W-1:0] merges
);
	logic [ADDR_W-1:0] clr_q;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [ENT_W-1:0]  ram_wdata, rdata;
	logic              ram_we;
	logic              mode_q;
	logic [NODE_W-1:0] a_q, b_q, cur_q, orig_q, ra_q, rb_q, sa_q, sb_q;
	logic [LVL_W-1:0]  lvl_q, w_q;
	logic [TOTAL_W-1:0] total_q;
	logic [MERGE_W-1:0] merges_q;
	logic [LVL_W:0]    mcnt_q;
	logic              side_q;
	logic [ADDR_W-1:0] base;
	logic [NODE_W-1:0] big_r, small_r;
	logic [NODE_W:0]   sum_sz;
	logic [TOTAL_W:0]  tsum;
	logic              swap;

	lufm_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(rdata)
	);

	assign base = ADDR_W'(lvl_q) * ADDR_W'(NODES);
	assign swap = sa_q < sb_q;
	assign big_r = swap ? rb_q : ra_q;
	assign small_r = swap ? ra_q : rb_q;
	assign sum_sz = {1'b0, sa_q} + {1'b0, sb_q} + 1'b1;

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = {1'b1, {NODE_W{1'b0}}};
		ram_raddr = base + ADDR_W'(cur_q);
		if (cmd.clear_step) begin
			ram_we = 1'b1;
		end else if (cmd.compress) begin
			ram_we = 1'b1;
			ram_waddr = base + ADDR_W'(cur_q);
			ram_wdata = {1'b0, side_q ? rb_q : ra_q};
		end else if (cmd.join_w) begin
			ram_we = 1'b1;
			ram_waddr = base + ADDR_W'(small_r);
			ram_wdata = {1'b0, big_r};
		end else if (cmd.size_w) begin
			ram_we = 1'b1;
			ram_waddr = base + ADDR_W'(big_r);
			ram_wdata = {1'b1, sum_sz[NODE_W-1:0]};
		end
	end

	assign sts.clear_done = (clr_q == ADDR_W'(DEPTH - 1));
	assign sts.is_root = rdata[NODE_W];
	assign sts.compress_done = rdata[NODE_W] || (rdata[NODE_W-1:0] == (side_q ? rb_q : ra_q));
	assign sts.same_set = ra_q == rb_q;
	assign sts.last_level = lvl_q == LVL_W'(LEVELS - 1);
	assign sts.skip = (w_q == '0) || (w_q > LVL_W'(LEVELS));
	assign tsum = {1'b0, total_q} + (TOTAL_W+1)'(w_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			total_q <= '0;
			merges_q <= '0;
			mcnt_q <= '0;
		end else begin
			if (cmd.clear_step) clr_q <= clr_q + 1'b1;
			if (cmd.start) mcnt_q <= '0;
			if (cmd.size_w) mcnt_q <= mcnt_q + 1'b1;
			if (cmd.finish) begin
				merges_q <= (mcnt_q > (LVL_W+1)'(MERGE_MAX)) ? MERGE_MAX : mcnt_q[MERGE_W-1:0];
				if (!sts.skip) begin
					if (!mode_q) total_q <= tsum[TOTAL_W] ? TOTAL_MAX : tsum[TOTAL_W-1:0];
					else if ({{(TOTAL_W-LVL_W-1){1'b0}}, mcnt_q} < total_q)
						total_q <= total_q - TOTAL_W'(mcnt_q);
					else total_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mode_q <= in_mode; a_q <= in_a; b_q <= in_b; w_q <= in_w;
			lvl_q <= in_w - 1'b1;
		end
		if (cmd.ld_a) begin cur_q <= a_q; orig_q <= a_q; side_q <= 1'b0; end
		if (cmd.ld_b) begin cur_q <= b_q; orig_q <= b_q; side_q <= 1'b1; end
		if (cmd.walk) begin
			if (rdata[NODE_W]) begin
				if (side_q) begin rb_q <= cur_q; sb_q <= rdata[NODE_W-1:0]; end
				else begin ra_q <= cur_q; sa_q <= rdata[NODE_W-1:0]; end
				cur_q <= orig_q;
			end else cur_q <= rdata[NODE_W-1:0];
		end
		if (cmd.compress && !sts.compress_done) cur_q <= rdata[NODE_W-1:0];
		if (cmd.next_level) lvl_q <= lvl_q + 1'b1;
	end

	assign total_weight = total_q;
	assign merges = merges_q;
endmodule

### hw/rtl/lufm_ctrl.sv
`timescale 1ns / 1ps
module lufm_ctrl import lufm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic out_free,
	input  logic out_fire,
	input  logic node_bad,
	input  sts_t sts,
	output cmd_t cmd,
	output logic in_ready,
	output logic out_valid
);
	localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_LVL = 4'd2, S_WAIT = 4'd3,
		S_WALK = 4'd4, S_CMP = 4'd5, S_JOIN = 4'd6, S_SIZE = 4'd7, S_NEXT = 4'd8,
		S_DONE = 4'd9, S_CW = 4'd10, S_CRD = 4'd11;
	logic [3:0] state_q;
	logic side_q, skip_q, valid_q;

	assign in_ready = (state_q == S_IDLE) && out_free;
	assign out_valid = valid_q;

	always_comb begin
		cmd = '0;
		cmd.start = in_fire;
		cmd.clear_step = state_q == S_CLR;
		cmd.ld_a = state_q == S_LVL;
		cmd.walk = state_q == S_WALK;
		cmd.compress = state_q == S_CMP && !sts.compress_done;
		cmd.ld_b = state_q == S_CMP && sts.compress_done && !side_q;
		cmd.join_w = state_q == S_JOIN && !sts.same_set;
		cmd.size_w = state_q == S_SIZE;
		cmd.next_level = state_q == S_NEXT;
		cmd.finish = state_q == S_DONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR; side_q <= 1'b0; skip_q <= 1'b0; valid_q <= 1'b0;
		end else begin
			if (out_fire) valid_q <= 1'b0;
			unique case (state_q)
				S_CLR: if (sts.clear_done) state_q <= S_IDLE;
				S_IDLE: if (in_fire) begin skip_q <= node_bad; state_q <= S_CW; end
				S_CW: state_q <= (skip_q || sts.skip) ? S_DONE : S_LVL;
				S_LVL: begin side_q <= 1'b0; state_q <= S_WAIT; end
				S_WAIT: state_q <= S_WALK;
				S_WALK: state_q <= sts.is_root ? S_CRD : S_WAIT;
				S_CRD: state_q <= S_CMP;
				S_CMP: if (sts.compress_done) begin
					if (side_q) state_q <= S_JOIN;
					else begin side_q <= 1'b1; state_q <= S_WAIT; end
				end else state_q <= S_CRD;
				S_JOIN: state_q <= sts.same_set ? S_NEXT : S_SIZE;
				S_SIZE: state_q <= S_NEXT;
				S_NEXT: state_q <= sts.last_level ? S_DONE : S_LVL;
				S_DONE: begin valid_q <= 1'b1; state_q <= S_IDLE; end
				default: state_q <= S_CLR;
			endcase
		end
	end
endmodule

### hw/rtl/layered_union_find_mst.sv
`timescale 1ns / 1ps
// Running MST weight over ten union-find forests held in one RAM. After reset a
// clearing pass over all 10240 entries runs before the first beat is taken. An item
// with a weight of 1 to 10 visits each level from its weight up, walking each
// endpoint's parent chain to the root and compressing it through the single read
// port, then joining the sets when they differ; one result beat per input beat.
module layered_union_find_mst import lufm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // node_a[9:0], node_b[19:10], weight[23:20]
	input  logic        s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // total_weight[13:0], merges[17:14]
);
	cmd_t cmd;
	sts_t sts;
	logic [TOTAL_W-1:0] total_weight;
	logic [MERGE_W-1:0] merges;
	logic in_fire;

	assign in_fire = s_tvalid && s_tready;

	lufm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.out_free(!m_tvalid || m_tready), .out_fire(m_tvalid && m_tready),
		.node_bad(1'b0), .sts(sts), .cmd(cmd), .in_ready(s_tready), .out_valid(m_tvalid)
	);

	lufm_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_mode(s_tuser), .in_a(s_tdata[9:0]), .in_b(s_tdata[19:10]),
		.in_w(s_tdata[23:20]), .total_weight(total_weight), .merges(merges)
	);

	assign m_tdata = {6'd0, merges, total_weight};
endmodule

### tb/sv/layered_union_find_mst_tb.sv
`timescale 1ns / 1ps
module layered_union_find_mst_tb;
	import lufm_pkg::*;

	class mst_scoreboard;
		logic [NODE_W-1:0] up [LEVELS][NODES];
		int unsigned set_sz [LEVELS][NODES];
		logic [TOTAL_W-1:0] total;
		logic [TOTAL_W-1:0] want_total [$];
		logic [MERGE_W-1:0] want_merges [$];
		int errors;
		int beats_out;

		function new();
			for (int l = 0; l < LEVELS; l++)
				for (int i = 0; i < NODES; i++) begin
					up[l][i] = i;
					set_sz[l][i] = 1;
				end
			total = '0;
			errors = 0;
			beats_out = 0;
		endfunction

		function int root_of(int l, int x);
			int r;
			int n;
			r = x;
			while (up[l][r] != r) r = up[l][r];
			while (up[l][x] != r) begin
				n = up[l][x];
				up[l][x] = r;
				x = n;
			end
			return r;
		endfunction

		function void note_edge(logic mode, logic [9:0] a, logic [9:0] b, logic [3:0] w);
			int m;
			int ra;
			int rb;
			int t;
			int sum;
			m = 0;
			if (w >= 1 && w <= LEVELS) begin
				for (int l = w - 1; l < LEVELS; l++) begin
					ra = root_of(l, a);
					rb = root_of(l, b);
					if (ra != rb) begin
						if (set_sz[l][ra] < set_sz[l][rb]) begin
							t = ra; ra = rb; rb = t;
						end
						set_sz[l][ra] += set_sz[l][rb];
						up[l][rb] = ra;
						m++;
					end
				end
				if (!mode) begin
					sum = total + w;
					total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum;
				end else
					total = (total > m) ? total - m : '0;
			end
			want_total.push_back(total);
			want_merges.push_back((m > MERGE_MAX) ? MERGE_MAX : m);
		endfunction

		function void check_result(logic [23:0] d);
			beats_out++;
			if (want_total.size() == 0) begin
				report("unexpected beat", d, 'x);
				return;
			end
			if (d[13:0] !== want_total[0])
				report("total_weight", d[13:0], want_total[0]);
			if (d[17:14] !== want_merges[0])
				report("merges", d[17:14], want_merges[0]);
			if (d[23:18] !== '0)
				report("pad bits", d[23:18], 0);
			void'(want_total.pop_front());
			void'(want_merges.pop_front());
		endfunction

		function void report(string what, logic [23:0] got, logic [23:0] exp);
			errors++;
			if (errors <= 40)
				$display("mismatch %s: got %0h expected %0h", what, got, exp);
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [23:0] s_tdata = '0;
	logic s_tuser = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [23:0] m_tdata;

	mst_scoreboard sb = new();
	int cycles = 0;
	int sent = 0;
	bit calm = 0;
	int idle_left = 0;
	int load_cnt = 0;
	int query_cnt = 0;
	localparam int LIMIT = 4000000;

	always #6 clk = ~clk;

	layered_union_find_mst DUT (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout");
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) sb.check_result(m_tdata);
		if (!arst_n) m_tready <= 0;
		else if (calm) m_tready <= 1;
		else if (idle_left > 0) begin
			idle_left <= idle_left - 1;
			m_tready <= 0;
		end else if ($urandom_range(0, 5) == 0) begin
			idle_left <= $urandom_range(1, 7) - 1;
			m_tready <= 0;
		end else m_tready <= 1;
	end

	task automatic send_edge(logic mode, logic [9:0] a, logic [9:0] b, logic [3:0] w);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= mode;
		s_tdata <= {w, b, a};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_edge(mode, a, b, w);
		if (mode) query_cnt++; else load_cnt++;
		sent++;
	endtask

	task automatic rand_edge(int span);
		logic [9:0] a;
		logic [9:0] b;
		logic [3:0] w;
		a = $urandom_range(0, span);
		b = $urandom_range(0, span);
		if ($urandom_range(0, 40) == 0) begin
			a = $urandom;
			b = $urandom;
		end
		w = ($urandom_range(0, 30) == 0) ? 4'($urandom) : 4'($urandom_range(1, LEVELS));
		send_edge($urandom_range(0, 1), a, b, w);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_edge(1, 0, 1, 1);
		send_edge(0, 0, 1, 1);
		send_edge(0, 1023, 1022, 10);
		send_edge(1, 1022, 1023, 10);
		send_edge(0, 5, 5, 3);
		send_edge(1, 7, 7, 3);
		send_edge(0, 2, 3, 0);
		send_edge(1, 2, 3, 11);
		send_edge(0, 2, 3, 15);
		send_edge(1, 0, 2, 4);
		send_edge(1, 0, 2, 1);
		send_edge(0, 10'h2AA, 10'h155, 5);
		send_edge(1, 10'h155, 10'h3FF, 1);
		send_edge(1, 10'h2AA, 0, 9);
		send_edge(0, 1, 3, 2);
		send_edge(1, 1, 3, 1);
		repeat (300) send_edge(0, $urandom_range(0, 1023), $urandom_range(0, 1023), 10);
		for (int i = 0; i < 200; i++) rand_edge(31);
		for (int i = 0; i < 234; i++) rand_edge(1023);
		calm = 1;
		s_tvalid <= 0;
		@(posedge clk);
		for (int i = 0; i < 200; i++) rand_edge(63);
		s_tvalid <= 0;
		while (sb.want_total.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("sent %0d beats (%0d loads, %0d queries), checked %0d results",
			sent, load_cnt, query_cnt, sb.beats_out);
		$display("covered underflow to zero, weights out of range, same endpoints, mixed loads and queries");
		if (sb.errors == 0 && sb.want_total.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

### files.f
hw/rtl/lufm_pkg.sv
hw/rtl/lufm_ram.sv
hw/rtl/lufm_datapath.sv
hw/rtl/lufm_ctrl.sv
hw/rtl/layered_union_find_mst.sv
tb/sv/layered_union_find_mst_tb.sv
